[hdl/assert_macros.svh]
// Assertion macros shared by the averager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while the reset is asserted.
`define BAL_ASSERT_RST(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion checked at every edge, reset included.
`define BAL_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/bal_pkg.sv]
// Package with the constants, types and helper functions of the battery level averager.
`timescale 1ns / 1ps
`default_nettype none

package bal_pkg;

	// Window length and width of one conversion result.
	localparam int SAMPLE_COUNT = 16;
	localparam int SAMPLE_BITS  = 12;

	// Configuration register data width and register index width.
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 3;

	// Number of level thresholds and width of the level code.
	localparam int LEVELS  = 5;
	localparam int LEVEL_W = 3;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(LEVELS);

	// Derived widths.
	localparam int CNT_W  = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
	localparam int SUM_W  = SAMPLE_BITS + $clog2(SAMPLE_COUNT) + 1;
	localparam int CORR_W = ((SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W) + 2;
	localparam int BOUND_W = ((CFG_W + 2 > SAMPLE_BITS) ? CFG_W + 2 : SAMPLE_BITS) + 1;
	localparam int CMP_W  = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;

	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CALIB_OFFSET = 3'd0,
		REG_FLUCT_THR    = 3'd1,
		REG_LEVEL1_THR   = 3'd2,
		REG_LEVEL2_THR   = 3'd3,
		REG_LEVEL3_THR   = 3'd4,
		REG_LEVEL4_THR   = 3'd5,
		REG_LEVEL5_THR   = 3'd6
	} cfg_reg_t;

	// Level thresholds, entry 0 is the level 1 threshold.
	typedef logic [LEVELS-1:0][CFG_W-1:0] lvl_thr_t;

	localparam lvl_thr_t LVL_THR_RESET = {
		CFG_W'(4095), CFG_W'(4095), CFG_W'(4095), CFG_W'(0), CFG_W'(0)
	};

	// Level of a reading: the first threshold, in ascending index order, that
	// lies above the reading gives the level; if none does, the level is full.
	function automatic logic [LEVEL_W-1:0] level_of(
		input logic [SAMPLE_BITS-1:0] value,
		input lvl_thr_t               thr
	);
		logic [LEVEL_W-1:0] lvl;
		lvl = LEVEL_MAX;
		for (int k = LEVELS - 1; k >= 0; k--) begin
			if (CMP_W'(value) < CMP_W'(thr[k])) begin
				lvl = LEVEL_W'(k);
			end
		end
		return lvl;
	endfunction

	// Offset correction with saturation to the sample range.
	function automatic logic [SAMPLE_BITS-1:0] correct_sample(
		input logic [SAMPLE_BITS-1:0] raw,
		input logic signed [CFG_W-1:0] offset
	);
		logic signed [CORR_W-1:0] sum;
		logic [SAMPLE_BITS-1:0]   res;
		sum = $signed(CORR_W'(raw)) + CORR_W'(offset);
		if (sum < 0) begin
			res = '0;
		end else if (sum > $signed(CORR_W'(SAMPLE_MAX))) begin
			res = SAMPLE_MAX;
		end else begin
			res = sum[SAMPLE_BITS-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

[hdl/bal_if.sv]
// Handshake interfaces of the battery level averager: samples, results and configuration.
`timescale 1ns / 1ps
`default_nettype none

interface bal_sample_if import bal_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface bal_result_if import bal_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] battery_value;
	logic [SAMPLE_BITS-1:0] previous_value;
	logic                   update_accepted;
	logic [LEVEL_W-1:0]     charge_level;
	logic                   level_changed;
	logic                   fluctuating;

	modport source (
		output valid, output battery_value, output previous_value,
		output update_accepted, output charge_level, output level_changed,
		output fluctuating, input ready
	);
	modport sink (
		input valid, input battery_value, input previous_value,
		input update_accepted, input charge_level, input level_changed,
		input fluctuating, output ready
	);
endinterface

interface bal_cfg_if import bal_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/battery_adc_average_level.sv]
// Battery level averager: offset correction, windowed mean, drop rejection and level report.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// The block takes one raw battery conversion result per cycle unless stalled,
// adds the signed calibration offset, clamps the corrected value to the sample
// range and sums SAMPLE_COUNT of them. At the end of each window the truncated
// mean is checked against the history reading: a mean more than four times the
// fluctuation threshold below the history is rejected as a sudden drop and
// leaves both readings as they are. An accepted mean moves the current reading
// into the history and becomes the current reading. Each window yields exactly
// one result transaction with both readings, the accepted flag, the charge level
// of the current reading (0 empty to 5 full, from the five level thresholds), a flag
// for a level change against the history reading, and a flag that is set when
// the two readings are at least the fluctuation threshold apart. Other samples
// yield nothing. The pipeline has three registers: the sample register, the
// mean register and the result register, through which the last sample of a
// window, its mean and its result pass in that order. One sample transaction
// is accepted every cycle unless the last sample of a window waits. A result
// that waits on the result channel does not stop the intake; only the last
// sample of the next window waits until the mean register has room.
// Configuration writes complete in the cycle they are offered and are meant for
// an idle block; writes to an index past the register list are dropped.
module battery_adc_average_level import bal_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	bal_sample_if.sink   samples,
	bal_cfg_if.sink      cfg,
	bal_result_if.source results
);

	// Configuration registers.
	logic signed [CFG_W-1:0] offset_q;
	logic [CFG_W-1:0]        fluct_q;
	lvl_thr_t                thr_q;

	// Window accumulation state.
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] sum_q;

	// Readings kept between windows.
	logic [SAMPLE_BITS-1:0] cur_q;
	logic [SAMPLE_BITS-1:0] hist_q;

	// Pipeline registers.
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   valid_s2;
	logic [SAMPLE_BITS-1:0] mean_s2;

	// Result register.
	logic                   valid_q;
	logic [SAMPLE_BITS-1:0] battery_q;
	logic [SAMPLE_BITS-1:0] previous_q;
	logic                   accepted_q;
	logic [LEVEL_W-1:0]     level_q;
	logic                   changed_q;
	logic                   fluct_flag_q;

	// Flow control.
	logic out_free;
	logic s2_free;
	logic s2_go;
	logic last_sample;
	logic s1_retire;
	logic in_xfer;

	// Stage 1 datapath.
	logic [SAMPLE_BITS-1:0] corr_s1;
	logic [SUM_W-1:0]       total_s1;

	// Stage 2 datapath.
	logic [BOUND_W-1:0]     drop_bound;
	logic                   accept;
	logic [SAMPLE_BITS-1:0] cur_nxt;
	logic [SAMPLE_BITS-1:0] hist_nxt;
	logic [LEVEL_W-1:0]     lvl_cur;
	logic [LEVEL_W-1:0]     lvl_hist;
	logic [SAMPLE_BITS-1:0] diff;

	// The result register frees up when it is empty or being read. The mean
	// register frees up when it is empty or moving into the result register.
	// A sample leaves stage 1 unless it closes a window and the mean register
	// is still occupied.
	assign out_free    = !valid_q || results.ready;
	assign s2_go       = valid_s2 && out_free;
	assign s2_free     = !valid_s2 || out_free;
	assign last_sample = (cnt_q == CNT_W'(SAMPLE_COUNT - 1));
	assign s1_retire   = valid_s1 && (!last_sample || s2_free);

	assign samples.ready = !valid_s1 || s1_retire;
	assign in_xfer       = samples.valid && samples.ready;

	assign cfg.ready = 1'b1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			fluct_q  <= '0;
			thr_q    <= LVL_THR_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_CALIB_OFFSET: offset_q <= $signed(cfg.data);
				REG_FLUCT_THR:    fluct_q <= cfg.data;
				REG_LEVEL1_THR:   thr_q[0] <= cfg.data;
				REG_LEVEL2_THR:   thr_q[1] <= cfg.data;
				REG_LEVEL3_THR:   thr_q[2] <= cfg.data;
				REG_LEVEL4_THR:   thr_q[3] <= cfg.data;
				REG_LEVEL5_THR:   thr_q[4] <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Stage 1: the accepted sample is held, corrected and added to the window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_s1 <= samples.sample;
		end
	end

	assign corr_s1  = correct_sample(sample_s1, offset_q);
	assign total_s1 = sum_q + SUM_W'(corr_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
		end else if (s1_retire) begin
			if (last_sample) begin
				cnt_q <= '0;
				sum_q <= '0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
				sum_q <= total_s1;
			end
		end
	end

	// Stage 2: the mean of a finished window waits for the decision.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_retire && last_sample;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_retire && last_sample) begin
			mean_s2 <= SAMPLE_BITS'(total_s1 / SAMPLE_COUNT);
		end
	end

	// Drop rejection: the mean is refused when the history lies above the mean
	// by more than four fluctuation thresholds.
	assign drop_bound = (BOUND_W'(fluct_q) << 2) + BOUND_W'(mean_s2);
	assign accept     = !(BOUND_W'(hist_q) > drop_bound);
	assign cur_nxt    = accept ? mean_s2 : cur_q;
	assign hist_nxt   = accept ? cur_q : hist_q;

	assign lvl_cur  = level_of(cur_nxt, thr_q);
	assign lvl_hist = level_of(hist_nxt, thr_q);
	assign diff     = (hist_nxt > cur_nxt) ? (hist_nxt - cur_nxt) : (cur_nxt - hist_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			hist_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				valid_q <= valid_s2;
			end
			if (s2_go) begin
				cur_q  <= cur_nxt;
				hist_q <= hist_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			battery_q    <= cur_nxt;
			previous_q   <= hist_nxt;
			accepted_q   <= accept;
			level_q      <= lvl_cur;
			changed_q    <= (lvl_hist != lvl_cur);
			fluct_flag_q <= (CMP_W'(diff) >= CMP_W'(fluct_q));
		end
	end

	assign results.valid           = valid_q;
	assign results.battery_value   = battery_q;
	assign results.previous_value  = previous_q;
	assign results.update_accepted = accepted_q;
	assign results.charge_level    = level_q;
	assign results.level_changed   = changed_q;
	assign results.fluctuating     = fluct_flag_q;

	// The window counter never runs past the last sample of a window.
	`BAL_ASSERT_ALWAYS(a_cnt_range, clk, cnt_q <= CNT_W'(SAMPLE_COUNT - 1), "window counter out of range")

	// A shown result never reports a level above full.
	`BAL_ASSERT_RST(a_level_range, clk, arst_n, results.valid |-> results.charge_level <= LEVEL_MAX, "charge level above full")

	// A rejected mean leaves both readings untouched.
	`BAL_ASSERT_RST(a_reject_holds, clk, arst_n, s2_go && !accept |=> $stable(cur_q) && $stable(hist_q), "rejected mean changed the readings")

	// A rejected result reports the readings that were already held.
	`BAL_ASSERT_RST(a_reject_report, clk, arst_n, s2_go && !accept |=> results.battery_value == cur_q && results.previous_value == hist_q, "rejected result reports other readings")

endmodule

`default_nettype wire
